@@ design/nsd_pkg.sv @@
// ----------------------------------------------------------------------------
// nsd_pkg: shared types and constants for the netstring deframer
// Byte classes, result kinds, error codes and the queue entry format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsd_pkg;

  // Longest length field, sign included
  localparam logic [3:0] MAX_LENGTH_CHARS = 4'd9;

  // Byte class decided by the front end
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_END,
    CLS_DIGIT,
    CLS_COLON,
    CLS_COMMA,
    CLS_PLUS,
    CLS_MINUS,
    CLS_SPACE
  } nsd_class_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } nsd_kind_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NO_DIGITS = 2'd0,
    ERR_COLON     = 2'd1,
    ERR_END       = 2'd2,
    ERR_COMMA     = 2'd3
  } nsd_err_t;

  // One classified request in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    nsd_class_t cls;
  } nsd_item_t;

endpackage

@@ design/nsd_in_if.sv @@
// ----------------------------------------------------------------------------
// nsd_in_if: byte stream channel
// Valid/ready channel carrying one stream byte or the end marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

@@ design/nsd_out_if.sv @@
// ----------------------------------------------------------------------------
// nsd_out_if: deframer result channel
// Valid/ready channel carrying payload bytes, frame-done and error results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [29:0] frame_length;
  logic [1:0]  error_code;

  modport source (output valid, output kind, output payload_byte, output frame_length,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_length,
                  input error_code, output ready);
endinterface

@@ design/nsd_front.sv @@
// ----------------------------------------------------------------------------
// nsd_front: byte classifier and request queue
// Classifies each incoming byte and stores it in a short FIFO for the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsd_front #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  nsd_in_if.sink             stream,
  output logic               item_valid,
  output nsd_pkg::nsd_item_t item,
  input  logic               item_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  nsd_pkg::nsd_item_t mem [DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [CW-1:0]      count;
  logic               push;
  logic               pop;
  nsd_pkg::nsd_item_t new_item;

  // Classify the incoming byte
  always_comb begin
    new_item.data_byte = stream.data_byte;
    if (stream.end_of_input) begin
      new_item.cls = nsd_pkg::CLS_END;
    end else if (stream.data_byte >= 8'h30 && stream.data_byte <= 8'h39) begin
      new_item.cls = nsd_pkg::CLS_DIGIT;
    end else if (stream.data_byte == 8'h3A) begin
      new_item.cls = nsd_pkg::CLS_COLON;
    end else if (stream.data_byte == 8'h2C) begin
      new_item.cls = nsd_pkg::CLS_COMMA;
    end else if (stream.data_byte == 8'h2B) begin
      new_item.cls = nsd_pkg::CLS_PLUS;
    end else if (stream.data_byte == 8'h2D) begin
      new_item.cls = nsd_pkg::CLS_MINUS;
    end else if (stream.data_byte == 8'h20 ||
                 (stream.data_byte >= 8'h09 && stream.data_byte <= 8'h0D)) begin
      new_item.cls = nsd_pkg::CLS_SPACE;
    end else begin
      new_item.cls = nsd_pkg::CLS_OTHER;
    end
  end

  assign stream.ready = (count != CW'(DEPTH));
  assign push         = stream.valid && stream.ready;
  assign item_valid   = (count != '0);
  assign pop          = item_pop && item_valid;
  assign item         = mem[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= new_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // Fill count never exceeds the depth
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("nsd_front: queue overfilled");

  // Pointers agree with the fill count when empty
  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("nsd_front: pointers out of step");

endmodule

@@ design/nsd_back.sv @@
// ----------------------------------------------------------------------------
// nsd_back: netstring parser and result register
// Walks the length, colon, payload and comma phases, one request per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  nsd_pkg::nsd_item_t item,
  output logic               item_pop,
  nsd_out_if.source          result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIGN,
    PH_DIGITS,
    PH_COLON,
    PH_PAYLOAD,
    PH_COMMA
  } phase_t;

  phase_t      phase, phase_next;
  logic [29:0] acc, acc_next;
  logic [3:0]  char_count, char_count_next;
  logic        neg, neg_next;
  logic [29:0] remaining, remaining_next;
  logic [29:0] held, held_next;

  logic               emit;
  nsd_pkg::nsd_kind_t emit_kind;
  nsd_pkg::nsd_err_t  emit_err;
  logic [29:0]        emit_len;

  logic        take;
  logic [29:0] acc_x10;
  logic [29:0] digit_acc;
  logic [3:0]  digit_count;
  logic [29:0] start_len;
  logic [29:0] remaining_dec;

  // Take a request whenever the result register is free or draining
  assign take     = item_valid && (!result.valid || result.ready);
  assign item_pop = take;

  // Length arithmetic
  assign acc_x10       = {acc[26:0], 3'b000} + {acc[28:0], 1'b0};
  assign digit_acc     = acc_x10 + 30'(item.data_byte[3:0]);
  assign digit_count   = char_count + 4'd1;
  assign start_len     = neg ? 30'd0 : acc;
  assign remaining_dec = remaining - 30'd1;

  // Next phase and result
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    char_count_next = char_count;
    neg_next        = neg;
    remaining_next  = remaining;
    held_next       = held;
    emit            = 1'b0;
    emit_kind       = nsd_pkg::KIND_ERROR;
    emit_err        = nsd_pkg::ERR_NO_DIGITS;
    emit_len        = '0;

    if (item.cls == nsd_pkg::CLS_END) begin
      phase_next = PH_IDLE;
      emit       = 1'b1;
      emit_err   = nsd_pkg::ERR_END;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          unique case (item.cls)
            nsd_pkg::CLS_SPACE: begin
            end
            nsd_pkg::CLS_PLUS, nsd_pkg::CLS_MINUS: begin
              neg_next        = (item.cls == nsd_pkg::CLS_MINUS);
              acc_next        = '0;
              char_count_next = 4'd1;
              if (4'd1 >= nsd_pkg::MAX_LENGTH_CHARS) begin
                emit = 1'b1;
              end else begin
                phase_next = PH_SIGN;
              end
            end
            nsd_pkg::CLS_DIGIT: begin
              neg_next        = 1'b0;
              acc_next        = 30'(item.data_byte[3:0]);
              char_count_next = 4'd1;
              phase_next      = (4'd1 >= nsd_pkg::MAX_LENGTH_CHARS) ? PH_COLON : PH_DIGITS;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
        PH_SIGN: begin
          if (item.cls == nsd_pkg::CLS_DIGIT) begin
            acc_next        = digit_acc;
            char_count_next = digit_count;
            phase_next = (digit_count >= nsd_pkg::MAX_LENGTH_CHARS) ? PH_COLON : PH_DIGITS;
          end else begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
          end
        end
        PH_DIGITS, PH_COLON: begin
          if (phase == PH_DIGITS && item.cls == nsd_pkg::CLS_DIGIT) begin
            acc_next        = digit_acc;
            char_count_next = digit_count;
            phase_next = (digit_count >= nsd_pkg::MAX_LENGTH_CHARS) ? PH_COLON : PH_DIGITS;
          end else if (item.cls == nsd_pkg::CLS_COLON) begin
            held_next      = start_len;
            remaining_next = start_len;
            phase_next     = (start_len != '0) ? PH_PAYLOAD : PH_COMMA;
          end else begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            emit_err   = nsd_pkg::ERR_COLON;
          end
        end
        PH_PAYLOAD: begin
          remaining_next = remaining_dec;
          if (remaining_dec == '0) begin
            phase_next = PH_COMMA;
          end
          emit      = 1'b1;
          emit_kind = nsd_pkg::KIND_PAYLOAD;
        end
        PH_COMMA: begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          if (item.cls == nsd_pkg::CLS_COMMA) begin
            emit_kind = nsd_pkg::KIND_DONE;
            emit_len  = held;
          end else begin
            emit_err = nsd_pkg::ERR_COMMA;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Hold parser state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      char_count   <= '0;
      neg          <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (take) begin
        phase      <= phase_next;
        char_count <= char_count_next;
        neg        <= neg_next;
      end
      if (take && emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      acc       <= acc_next;
      remaining <= remaining_next;
      held      <= held_next;
      if (emit) begin
        result.kind         <= emit_kind;
        result.payload_byte <= (emit_kind == nsd_pkg::KIND_PAYLOAD) ? item.data_byte : 8'd0;
        result.frame_length <= emit_len;
        result.error_code   <= (emit_kind == nsd_pkg::KIND_ERROR) ? emit_err
                                                                  : nsd_pkg::ERR_NO_DIGITS;
      end
    end
  end

  // Payload phase always has bytes left to pass
  assert property (@(posedge clk) disable iff (rst) (phase == PH_PAYLOAD) |-> (remaining != '0))
    else $error("nsd_back: payload phase with nothing remaining");

  // Length field never grows past the character limit
  assert property (@(posedge clk) disable iff (rst)
      (phase == PH_SIGN || phase == PH_DIGITS || phase == PH_COLON)
      |-> (char_count <= nsd_pkg::MAX_LENGTH_CHARS))
    else $error("nsd_back: length field over limit");

  // A waiting frame-done result reports the latched length
  assert property (@(posedge clk) disable iff (rst)
      (result.valid && result.kind == nsd_pkg::KIND_DONE) |-> (result.frame_length == held))
    else $error("nsd_back: frame length mismatch");

  // A stalled result blocks the parser
  assert property (@(posedge clk) disable iff (rst)
      (result.valid && !result.ready) |-> !take)
    else $error("nsd_back: request taken while result stalled");

endmodule

@@ design/netstring_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// netstring_deframer_unit: streaming netstring decoder
// Decodes <length>:<payload>, frames from a byte stream, one byte a request.
//
//   channel  role   payload                                      handshake
//   stream   sink   data_byte[7:0], end_of_input                 valid/ready
//   result   source kind[1:0], payload_byte[7:0],                valid/ready
//                   frame_length[29:0], error_code[1:0]
//
// One request per cycle sustained while the result is not stalled; the parser
// handles each byte by a compare, multiply-by-ten with add, or countdown.
// From stream accept to result valid, the request lands in the classifier
// queue at the accept edge and the parser then registers its result in the
// output register.
// Reset is synchronous; the block takes requests the cycle after rst falls.
// The queue of QUEUE_DEPTH entries absorbs result-side stalls; the parser
// holds while an undelivered result sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module netstring_deframer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  nsd_in_if.sink    stream,
  nsd_out_if.source result
);

  logic               item_valid;
  nsd_pkg::nsd_item_t item;
  logic               item_pop;

  nsd_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  nsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .result     (result)
  );

endmodule
